FILE: src/riffms_pkg.sv
// Package for the RIFF MIDI-stream parser: phase codes, result and error
// codes, chunk tags and the result record type.
// No dependencies.
`default_nettype none

package riffms_pkg;

  // Default width of the running tick time
  localparam int TICK_WIDTH_DEF = 32;

  // Chunk tags as little-endian words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_MIDS = 32'h5344_494D;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_LEN  = 32'h0000_000C;

  // Tempo meta event markers
  localparam logic [7:0] META_STATUS = 8'hFF;
  localparam logic [7:0] META_TEMPO  = 8'h51;

  // Event word type in its top byte
  localparam logic [7:0] EVT_SHORT = 8'h00;
  localparam logic [7:0] EVT_TEMPO = 8'h01;

  // Result kinds
  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_SHORT  = 3'd1;
  localparam logic [2:0] KIND_TEMPO  = 3'd2;
  localparam logic [2:0] KIND_ERROR  = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_RIFF_TAG = 3'd0;
  localparam logic [2:0] ERR_FORM_TAG = 3'd1;
  localparam logic [2:0] ERR_FMT_LEN  = 3'd2;
  localparam logic [2:0] ERR_DATA_TAG = 3'd3;
  localparam logic [2:0] ERR_EVT_TYPE = 3'd4;

  // Parser phase, one-hot
  typedef enum logic [15:0] {
    PH_RIFF   = 16'h0001,
    PH_RSIZE  = 16'h0002,
    PH_MIDS   = 16'h0004,
    PH_FMT    = 16'h0008,
    PH_FLEN   = 16'h0010,
    PH_DIVS   = 16'h0020,
    PH_SKIP   = 16'h0040,
    PH_FLAGS  = 16'h0080,
    PH_DATA   = 16'h0100,
    PH_DSIZE  = 16'h0200,
    PH_BCOUNT = 16'h0400,
    PH_BHEAD  = 16'h0800,
    PH_BSIZE  = 16'h1000,
    PH_DELTA  = 16'h2000,
    PH_SID    = 16'h4000,
    PH_EVENT  = 16'h8000
  } phase_t;

  // One result record
  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  error_code;
    logic [31:0] divisions;
    logic [23:0] tempo_value;
    logic [7:0]  second_data;
    logic [7:0]  first_data;
    logic [7:0]  status_value;
    logic [31:0] tick_time;
    logic [31:0] event_index;
  } result_t;

endpackage

`default_nettype wire

FILE: src/riff_midi_stream_parser.sv
// RIFF MIDI-stream parser top level: byte-wise header check, block walk and
// event decode with a two-entry result buffer.
// Depends on riffms_pkg.
//
// channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready  | tdata: data_in; tuser: start_of_file
// out_    | out | out_tvalid/out_tready| tuser: result_kind; tdata: result
//
// One byte per cycle while in_tready is high; a byte's result (if any) is set by
// the decode logic between state and result registers, then shows on out_.
// The result register plus one skid entry let input run on while a result
// waits; in_tready drops only when both entries are full.
// rst_n is synchronous, active low; start_of_file restarts parsing in-band.
`default_nettype none

module riff_midi_stream_parser #(
  parameter int TICK_WIDTH = riffms_pkg::TICK_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] data_in
  input  wire logic         in_tuser,   // [0] start_of_file
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [151:0]      out_tdata,  // [31:0] event_index, [63:32] tick_time,
                                        // [71:64] status_value, [79:72] first_data,
                                        // [87:80] second_data, [111:88] tempo_value,
                                        // [143:112] divisions, [146:144] error_code,
                                        // [151:147] zero
  output logic [2:0]        out_tuser   // [2:0] result_kind
);

  // Parser state
  riffms_pkg::phase_t      phase_r, phase_nxt;
  logic [1:0]              pos_r, pos_nxt;
  logic [23:0]             word_r, word_nxt;
  logic [TICK_WIDTH-1:0]   ticks_r, ticks_nxt;
  logic [31:0]             count_r, count_nxt;
  logic [31:0]             blocks_r, blocks_nxt;
  logic [31:0]             bsize_r, bsize_nxt;
  logic [31:0]             bdone_r, bdone_nxt;
  logic                    has_sid_r, has_sid_nxt;
  logic                    err_r, err_nxt;

  // Result buffer
  riffms_pkg::result_t     out_r, out_nxt, skid_r, skid_nxt;
  logic                    out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;

  // Per-request values after an optional restart
  riffms_pkg::phase_t      phase_e;
  logic [1:0]              pos_e;
  logic [23:0]             word_e;
  logic [TICK_WIDTH-1:0]   ticks_e;
  logic [31:0]             count_e, blocks_e, bsize_e, bdone_e;
  logic                    has_sid_e, err_e;

  logic                    acc, push, pop;
  riffms_pkg::result_t     res;
  logic [31:0]             w;
  logic [31:0]             blocks_dec;

  assign acc       = in_tvalid && in_tready;
  assign in_tready = !skid_v_r;
  assign pop       = out_v_r && out_tready;

  // Decode one byte
  always_comb begin
    phase_e   = in_tuser ? riffms_pkg::PH_RIFF : phase_r;
    pos_e     = in_tuser ? 2'd0 : pos_r;
    word_e    = in_tuser ? 24'd0 : word_r;
    ticks_e   = in_tuser ? '0 : ticks_r;
    count_e   = in_tuser ? 32'd0 : count_r;
    blocks_e  = in_tuser ? 32'd0 : blocks_r;
    bsize_e   = in_tuser ? 32'd0 : bsize_r;
    bdone_e   = in_tuser ? 32'd0 : bdone_r;
    has_sid_e = in_tuser ? 1'b0 : has_sid_r;
    err_e     = in_tuser ? 1'b0 : err_r;

    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    word_nxt    = word_r;
    ticks_nxt   = ticks_r;
    count_nxt   = count_r;
    blocks_nxt  = blocks_r;
    bsize_nxt   = bsize_r;
    bdone_nxt   = bdone_r;
    has_sid_nxt = has_sid_r;
    err_nxt     = err_r;
    push        = 1'b0;
    res         = '0;
    w           = {in_tdata, word_e};
    blocks_dec  = blocks_e - 32'd1;

    if (acc) begin
      phase_nxt   = phase_e;
      pos_nxt     = pos_e;
      word_nxt    = word_e;
      ticks_nxt   = ticks_e;
      count_nxt   = count_e;
      blocks_nxt  = blocks_e;
      bsize_nxt   = bsize_e;
      bdone_nxt   = bdone_e;
      has_sid_nxt = has_sid_e;
      err_nxt     = err_e;

      // Drop bytes after an error or after the end of stream
      if (!err_e && !(phase_e == riffms_pkg::PH_BHEAD && blocks_e == 32'd0)) begin
        // Count bytes inside a block, saturating
        if ((phase_e == riffms_pkg::PH_DELTA || phase_e == riffms_pkg::PH_SID ||
             phase_e == riffms_pkg::PH_EVENT) && bdone_e != 32'hFFFF_FFFF) begin
          bdone_nxt = bdone_e + 32'd1;
        end

        if (pos_e != 2'd3) begin
          // Gather the word, low byte first
          word_nxt = word_e | (24'(in_tdata) << {pos_e, 3'b000});
          pos_nxt  = pos_e + 2'd1;
        end else begin
          word_nxt = 24'd0;
          pos_nxt  = 2'd0;
          case (phase_e)
            riffms_pkg::PH_RIFF: begin
              if (w != riffms_pkg::TAG_RIFF) begin
                err_nxt        = 1'b1;
                push           = 1'b1;
                res.kind       = riffms_pkg::KIND_ERROR;
                res.error_code = riffms_pkg::ERR_RIFF_TAG;
              end else begin
                phase_nxt = riffms_pkg::PH_RSIZE;
              end
            end
            riffms_pkg::PH_RSIZE: phase_nxt = riffms_pkg::PH_MIDS;
            riffms_pkg::PH_MIDS: begin
              if (w != riffms_pkg::TAG_MIDS) begin
                err_nxt        = 1'b1;
                push           = 1'b1;
                res.kind       = riffms_pkg::KIND_ERROR;
                res.error_code = riffms_pkg::ERR_FORM_TAG;
              end else begin
                phase_nxt = riffms_pkg::PH_FMT;
              end
            end
            riffms_pkg::PH_FMT: begin
              if (w != riffms_pkg::TAG_FMT) begin
                err_nxt        = 1'b1;
                push           = 1'b1;
                res.kind       = riffms_pkg::KIND_ERROR;
                res.error_code = riffms_pkg::ERR_FORM_TAG;
              end else begin
                phase_nxt = riffms_pkg::PH_FLEN;
              end
            end
            riffms_pkg::PH_FLEN: begin
              if (w != riffms_pkg::FMT_LEN) begin
                err_nxt        = 1'b1;
                push           = 1'b1;
                res.kind       = riffms_pkg::KIND_ERROR;
                res.error_code = riffms_pkg::ERR_FMT_LEN;
              end else begin
                phase_nxt = riffms_pkg::PH_DIVS;
              end
            end
            riffms_pkg::PH_DIVS: begin
              phase_nxt     = riffms_pkg::PH_SKIP;
              push          = 1'b1;
              res.kind      = riffms_pkg::KIND_HEADER;
              res.divisions = w;
            end
            riffms_pkg::PH_SKIP: phase_nxt = riffms_pkg::PH_FLAGS;
            riffms_pkg::PH_FLAGS: begin
              has_sid_nxt = !w[0];
              phase_nxt   = riffms_pkg::PH_DATA;
            end
            riffms_pkg::PH_DATA: begin
              if (w != riffms_pkg::TAG_DATA) begin
                err_nxt        = 1'b1;
                push           = 1'b1;
                res.kind       = riffms_pkg::KIND_ERROR;
                res.error_code = riffms_pkg::ERR_DATA_TAG;
              end else begin
                phase_nxt = riffms_pkg::PH_DSIZE;
              end
            end
            riffms_pkg::PH_DSIZE: phase_nxt = riffms_pkg::PH_BCOUNT;
            riffms_pkg::PH_BCOUNT: begin
              blocks_nxt = w;
              phase_nxt  = riffms_pkg::PH_BHEAD;
              if (w == 32'd0) begin
                push            = 1'b1;
                res.kind        = riffms_pkg::KIND_END;
                res.event_index = count_e;
                res.tick_time   = 32'(ticks_e);
              end
            end
            riffms_pkg::PH_BHEAD: phase_nxt = riffms_pkg::PH_BSIZE;
            riffms_pkg::PH_BSIZE: begin
              bsize_nxt = w;
              bdone_nxt = 32'd0;
              if (w == 32'd0) begin
                // Empty block: move to the next one or end the stream
                blocks_nxt = blocks_dec;
                phase_nxt  = riffms_pkg::PH_BHEAD;
                if (blocks_dec == 32'd0) begin
                  push            = 1'b1;
                  res.kind        = riffms_pkg::KIND_END;
                  res.event_index = count_e;
                  res.tick_time   = 32'(ticks_e);
                end
              end else begin
                phase_nxt = riffms_pkg::PH_DELTA;
              end
            end
            riffms_pkg::PH_DELTA: begin
              ticks_nxt = ticks_e + TICK_WIDTH'(w);
              phase_nxt = has_sid_e ? riffms_pkg::PH_SID : riffms_pkg::PH_EVENT;
            end
            riffms_pkg::PH_SID: phase_nxt = riffms_pkg::PH_EVENT;
            riffms_pkg::PH_EVENT: begin
              if (w[31:24] != riffms_pkg::EVT_SHORT && w[31:24] != riffms_pkg::EVT_TEMPO) begin
                err_nxt        = 1'b1;
                push           = 1'b1;
                res.kind       = riffms_pkg::KIND_ERROR;
                res.error_code = riffms_pkg::ERR_EVT_TYPE;
              end else begin
                push            = 1'b1;
                res.event_index = count_e;
                res.tick_time   = 32'(ticks_e);
                if (w[31:24] == riffms_pkg::EVT_TEMPO) begin
                  res.kind         = riffms_pkg::KIND_TEMPO;
                  res.status_value = riffms_pkg::META_STATUS;
                  res.first_data   = riffms_pkg::META_TEMPO;
                  res.tempo_value  = w[23:0];
                end else begin
                  res.kind         = riffms_pkg::KIND_SHORT;
                  res.status_value = w[7:0];
                  res.first_data   = w[15:8];
                  res.second_data  = w[23:16];
                end
                count_nxt = count_e + 32'd1;
                // An event that reaches the block end closes the block
                if (bdone_nxt >= bsize_e) begin
                  blocks_nxt = blocks_dec;
                  phase_nxt  = riffms_pkg::PH_BHEAD;
                end else begin
                  phase_nxt = riffms_pkg::PH_DELTA;
                end
              end
            end
            default: phase_nxt = phase_e;
          endcase
        end
      end
    end
  end

  // Result buffer: output register in front, skid entry behind it
  always_comb begin
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (pop || !out_v_r) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        out_nxt   = res;
        out_v_nxt = push;
      end
    end else if (push) begin
      skid_nxt   = res;
      skid_v_nxt = 1'b1;
    end
  end

  // Control state and buffer flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= riffms_pkg::PH_RIFF;
      pos_r     <= 2'd0;
      word_r    <= 24'd0;
      ticks_r   <= '0;
      count_r   <= 32'd0;
      blocks_r  <= 32'd0;
      bsize_r   <= 32'd0;
      bdone_r   <= 32'd0;
      has_sid_r <= 1'b0;
      err_r     <= 1'b0;
      out_v_r   <= 1'b0;
      skid_v_r  <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      word_r    <= word_nxt;
      ticks_r   <= ticks_nxt;
      count_r   <= count_nxt;
      blocks_r  <= blocks_nxt;
      bsize_r   <= bsize_nxt;
      bdone_r   <= bdone_nxt;
      has_sid_r <= has_sid_nxt;
      err_r     <= err_nxt;
      out_v_r   <= out_v_nxt;
      skid_v_r  <= skid_v_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {5'd0, out_r.error_code, out_r.divisions, out_r.tempo_value,
                       out_r.second_data, out_r.first_data, out_r.status_value,
                       out_r.tick_time, out_r.event_index};

  // Skid entry is only ever filled behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry valid while output register empty");

  // A latched error silences every byte until a restart
  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && err_r && !in_tuser) |-> !push)
    else $error("result produced while error latched");

  // An error result latches the error
  a_err_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.kind == riffms_pkg::KIND_ERROR) |=> err_r)
    else $error("error result without latched error");

  // Event results advance the event counter by one
  a_evt_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (res.kind == riffms_pkg::KIND_SHORT || res.kind == riffms_pkg::KIND_TEMPO))
    |=> count_r == $past(res.event_index) + 32'd1)
    else $error("event counter did not advance");

endmodule

`default_nettype wire
